@@ hw/rtl/pnlp_pkg.sv @@
// Shared types and character constants for the number literal parser.
package pnlp_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned BASE_W = 5;
    localparam int unsigned RES_W  = 32;
    localparam int unsigned POS_W  = 3;

    localparam logic [CH_W-1:0] CH_HASH    = 8'h23;
    localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CH_W-1:0] CH_QUOTE   = 8'h27;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;

    localparam logic [BASE_W-1:0] BASE_TWO     = 5'd2;
    localparam logic [BASE_W-1:0] BASE_TEN     = 5'd10;
    localparam logic [BASE_W-1:0] BASE_SIXTEEN = 5'd16;

    localparam logic [POS_W-1:0] POS_FIRST  = 3'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 3'd1;
    localparam logic [POS_W-1:0] POS_THIRD  = 3'd2;
    localparam logic [POS_W-1:0] POS_MAX    = 3'd7;

    typedef enum logic [2:0] {
        PH_START,
        PH_HASH,
        PH_DOLLAR,
        PH_PERCENT,
        PH_SIGN,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic       is_hash;
        logic       is_dollar;
        logic       is_percent;
        logic       is_minus;
        logic       is_quote;
        logic       digit_ok;
        logic [3:0] digit;
    } t_char_info;

endpackage

@@ hw/rtl/pnlp_if.sv @@
// Handshake channel interfaces: character input, result output, base write.
interface pnlp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface pnlp_result_if;
    logic               valid;
    logic               ready;
    logic               is_number;
    logic signed [31:0] value;

    modport source (output valid, output is_number, output value, input ready);
    modport sink   (input valid, input is_number, input value, output ready);
endinterface

interface pnlp_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/pnlp_char_dec.sv @@
// Character classifier: prefix/sign/quote detection and digit value for a base.
module pnlp_char_dec
    import pnlp_pkg::*;
(
    input  logic [CH_W-1:0]   i_ch,
    input  logic [BASE_W-1:0] i_base,
    output t_char_info        o_info
);

    logic [CH_W-1:0] num_off;
    logic [CH_W-1:0] low_off;
    logic [CH_W-1:0] up_off;
    logic            is_num;
    logic            is_low;
    logic            is_up;
    logic            hex_base;

    assign num_off  = i_ch - CH_ZERO;
    assign low_off  = i_ch - CH_LOWER_A;
    assign up_off   = i_ch - CH_UPPER_A;
    assign is_num   = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_low   = (i_ch >= CH_LOWER_A) && (i_ch <= CH_LOWER_F);
    assign is_up    = (i_ch >= CH_UPPER_A) && (i_ch <= CH_UPPER_F);
    assign hex_base = (i_base == BASE_SIXTEEN);

    always_comb begin
        o_info            = '0;
        o_info.is_hash    = (i_ch == CH_HASH);
        o_info.is_dollar  = (i_ch == CH_DOLLAR);
        o_info.is_percent = (i_ch == CH_PERCENT);
        o_info.is_minus   = (i_ch == CH_MINUS);
        o_info.is_quote   = (i_ch == CH_QUOTE);
        if (is_num) begin
            o_info.digit    = num_off[3:0];
            // small bases reject numerals at or above the base
            o_info.digit_ok = (i_base >= BASE_TEN) || ({1'b0, num_off[3:0]} < i_base);
        end else if (hex_base && is_low) begin
            o_info.digit    = low_off[3:0] + 4'd10;
            o_info.digit_ok = 1'b1;
        end else if (hex_base && is_up) begin
            o_info.digit    = up_off[3:0] + 4'd10;
            o_info.digit_ok = 1'b1;
        end
    end

endmodule

@@ hw/rtl/prefixed_number_literal_parser.sv @@
// Top level: prefixed number literal parser, one character per transfer.
//
//  channel  | dir | payload                | transfer when
//  ---------+-----+------------------------+-----------------------
//  i_in     | in  | ch[7:0], last          | valid & ready
//  o_out    | out | is_number, value[31:0] | valid & ready
//  i_cfg    | in  | data[4:0] (base)       | valid & ready (ready tied high)
//
// One character per cycle. Each accepted character updates the token state
// (accumulator multiply-add by the base) in the cycle it is transferred; the
// final character of a token loads the result register, visible next cycle.
// i_in.ready drops only while a result is held and o_out.ready is low.
// Synchronous active-low reset clears token state and sets the base to ten.
module prefixed_number_literal_parser
    import pnlp_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pnlp_char_if.sink     i_in,
    pnlp_result_if.source o_out,
    pnlp_cfg_if.sink      i_cfg
);

    localparam int unsigned EXT_W = (VALUE_BITS > RES_W) ? VALUE_BITS : RES_W;

    logic [BASE_W-1:0]     r_default_base;
    logic [POS_W-1:0]      r_pos,        n_pos;
    t_phase                r_phase,      n_phase;
    logic [BASE_W-1:0]     r_cur_base,   n_cur_base;
    logic                  r_neg,        n_neg;
    logic [VALUE_BITS-1:0] r_accum,      n_accum;
    logic                  r_seen,       n_seen;
    logic                  r_bad,        n_bad;
    logic [CH_W-1:0]       r_quoted,     n_quoted;
    logic                  r_quote_ok,   n_quote_ok;
    logic                  r_out_valid;
    logic                  r_is_number,  n_is_number;
    logic [RES_W-1:0]      r_value,      n_value;

    logic                  take;
    logic [BASE_W-1:0]     base_eff;
    t_char_info            info;
    logic [VALUE_BITS-1:0] signed_val;
    logic [EXT_W-1:0]      ext_val;

    assign take         = i_in.valid && i_in.ready;
    assign i_in.ready   = !r_out_valid || o_out.ready;
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_out_valid;
    assign o_out.is_number = r_is_number;
    assign o_out.value  = r_value;

    // base is latched from the register at the first character of a token
    assign base_eff = (r_pos == POS_FIRST) ? r_default_base : r_cur_base;

    pnlp_char_dec u_dec (
        .i_ch   (i_in.ch),
        .i_base (base_eff),
        .o_info (info)
    );

    // token state update for one character
    always_comb begin
        n_pos      = (r_pos == POS_MAX) ? r_pos : r_pos + 3'd1;
        n_phase    = r_phase;
        n_cur_base = base_eff;
        n_neg      = r_neg;
        n_accum    = r_accum;
        n_seen     = r_seen;
        n_bad      = r_bad;
        n_quoted   = r_quoted;
        n_quote_ok = r_quote_ok;

        if (r_pos == POS_FIRST) begin
            n_quote_ok = info.is_quote;
        end else if (r_pos == POS_SECOND) begin
            n_quoted = i_in.ch;
        end else if (r_pos == POS_THIRD) begin
            n_quote_ok = r_quote_ok && info.is_quote;
        end

        if (!r_bad) begin
            if (info.is_hash && r_phase == PH_START) begin
                n_cur_base = BASE_TEN;
                n_phase    = PH_HASH;
            end else if (info.is_dollar && r_phase <= PH_HASH) begin
                n_cur_base = BASE_SIXTEEN;
                n_phase    = PH_DOLLAR;
            end else if (info.is_percent && r_phase <= PH_DOLLAR) begin
                n_cur_base = BASE_TWO;
                n_phase    = PH_PERCENT;
            end else if (info.is_minus && r_phase <= PH_PERCENT
                         && base_eff == BASE_TEN) begin
                n_neg   = 1'b1;
                n_phase = PH_SIGN;
            end else if (info.digit_ok) begin
                n_accum = r_accum * VALUE_BITS'(base_eff) + VALUE_BITS'(info.digit);
                n_seen  = 1'b1;
                n_phase = PH_DIGITS;
            end else begin
                n_bad = 1'b1;
            end
        end
    end

    // result for a token ending on this character
    assign signed_val = n_neg ? (VALUE_BITS'(0) - n_accum) : n_accum;
    assign ext_val    = EXT_W'($signed(signed_val));

    always_comb begin
        if (r_pos == POS_THIRD && n_quote_ok) begin
            n_is_number = 1'b1;
            n_value     = RES_W'(r_quoted);
        end else if (!n_bad && n_seen) begin
            n_is_number = 1'b1;
            n_value     = ext_val[RES_W-1:0];
        end else begin
            n_is_number = 1'b0;
            n_value     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_base <= BASE_TEN;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_default_base <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_FIRST;
            r_phase    <= PH_START;
            r_cur_base <= BASE_TEN;
            r_neg      <= 1'b0;
            r_accum    <= '0;
            r_seen     <= 1'b0;
            r_bad      <= 1'b0;
            r_quoted   <= '0;
            r_quote_ok <= 1'b0;
        end else if (take && i_in.last) begin
            r_pos      <= POS_FIRST;
            r_phase    <= PH_START;
            r_cur_base <= BASE_TEN;
            r_neg      <= 1'b0;
            r_accum    <= '0;
            r_seen     <= 1'b0;
            r_bad      <= 1'b0;
            r_quoted   <= '0;
            r_quote_ok <= 1'b0;
        end else if (take) begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_cur_base <= n_cur_base;
            r_neg      <= n_neg;
            r_accum    <= n_accum;
            r_seen     <= n_seen;
            r_bad      <= n_bad;
            r_quoted   <= n_quoted;
            r_quote_ok <= n_quote_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_in.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in.last) begin
            r_is_number <= n_is_number;
            r_value     <= n_value;
        end
    end

endmodule
